// ===== rtl/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 hash engine.
// Used by md5_round, md5_msg_store and md5_hash_engine; no dependencies.

package md5_pkg;

   localparam int WordWidth = 32;
   localparam int StoreWords = 16;
   localparam int RoundCount = 64;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_OFFSET = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   localparam logic [0:0] OP_BYTE = 1'b0;
   localparam logic [0:0] OP_FINISH = 1'b1;

   localparam logic [1:0] IDX_A = 2'd0;
   localparam logic [1:0] IDX_B = 2'd1;
   localparam logic [1:0] IDX_C = 2'd2;
   localparam logic [1:0] IDX_D = 2'd3;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5_work_type;

   typedef struct packed {
      logic       en;
      logic [5:0] addr;
      logic [7:0] data;
   } md5_store_wr_type;

   localparam logic [31:0] ROUND_CONST [RoundCount] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a given round.
   function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
      logic [7:0] n;
      logic [7:0] k;
      begin
         n = {4'b0000, rnd[3:0]};
         case (rnd[5:4])
            2'd0: k = n;
            2'd1: k = (n << 2) + n + 8'd1;
            2'd2: k = (n << 1) + n + 8'd5;
            default: k = (n << 3) - n;
         endcase
         return k[3:0];
      end
   endfunction

endpackage

// ===== rtl/md5_round.sv =====
// One MD5 round step, shared by all 64 rounds of a block compression.
// Depends on md5_pkg for the work type and the round tables.

module md5_round
   import md5_pkg::*;
(
   input  md5_work_type work_cur,
   input  logic [5:0]   round_idx,
   input  logic [31:0]  msg_word,
   output md5_work_type work_nxt
);

   logic [31:0] mix;
   logic [31:0] sum;
   logic [63:0] rot_dbl;
   logic [4:0]  rot;

   always_comb begin
      case (round_idx[5:4])
         2'd0: mix = (work_cur.b & work_cur.c) | (~work_cur.b & work_cur.d);
         2'd1: mix = (work_cur.d & work_cur.b) | (~work_cur.d & work_cur.c);
         2'd2: mix = work_cur.b ^ work_cur.c ^ work_cur.d;
         default: mix = work_cur.c ^ (work_cur.b | ~work_cur.d);
      endcase
   end

   assign rot = ROT_AMOUNT[{round_idx[5:4], round_idx[1:0]}];
   assign sum = mix + work_cur.a + ROUND_CONST[round_idx] + msg_word;
   assign rot_dbl = {sum, sum} << rot;

   assign work_nxt.a = work_cur.d;
   assign work_nxt.d = work_cur.c;
   assign work_nxt.c = work_cur.b;
   assign work_nxt.b = work_cur.b + rot_dbl[63:32];

endmodule

// ===== rtl/md5_msg_store.sv =====
// 64-byte message block store, written a byte at a time and read a word at a time.
// Depends on md5_pkg for the write struct and store sizes.

module md5_msg_store
   import md5_pkg::*;
(
   input  logic             clock,
   input  md5_store_wr_type wr,
   input  logic [3:0]       rd_addr,
   output logic [31:0]      rd_word
);

   logic [31:0] mem_ff [StoreWords];
   logic [31:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[5:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
      end
      rd_word_ff <= mem_ff[rd_addr];
   end

   assign rd_word = rd_word_ff;

endmodule

// ===== rtl/md5_hash_engine.sv =====
// Top level of the MD5 hash engine: sequencer, chaining words and digest output.
// Depends on md5_pkg, md5_msg_store and md5_round.
//
//   channel   direction  tdata              tuser             tlast
//   req       in         data_byte[7:0]     op                -
//   rsp       out        digest_word[31:0]  word_index[1:0]   last_word
//
// A message byte is written into the store; when it completes a block, the engine then
// prefetches the first message word, runs the rounds through the round unit and folds into the chain.
// A finish word writes 9 to 72 padding bytes at one per cycle with one or two block
// compressions, then sends the four digest words, each held until it is taken.
// Reset is synchronous and restores the initial chaining words and a zero byte count.
// Output stalls hold the sequencer; no input word is taken until the digest has left.

module md5_hash_engine
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic [0:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word[31:0]
   output logic [1:0]  rsp_tuser,   // word_index[1:0]
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   md5_work_type     chain_ff, chain_in;
   md5_work_type     work_ff, work_in;
   md5_work_type     work_rnd;
   logic [63:0]      count_ff, count_in;
   logic [63:0]      bits_ff, bits_in;
   logic [5:0]       round_ff, round_in;
   logic             finishing_ff, finishing_in;
   logic             pad_first_ff, pad_first_in;
   logic             len_zone_ff, len_zone_in;
   logic             len_done_ff, len_done_in;
   logic [1:0]       emit_idx_ff, emit_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_user_ff, rsp_user_in;
   logic             rsp_last_ff, rsp_last_in;
   md5_store_wr_type store_wr;
   logic [3:0]       store_rd_addr;
   logic [31:0]      store_rd_word;
   logic [5:0]       offset;
   logic [7:0]       pad_byte;
   logic [31:0]      emit_word;
   logic             req_fire;

   md5_msg_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (store_rd_addr),
      .rd_word (store_rd_word)
   );

   md5_round u_round (
      .work_cur  (work_ff),
      .round_idx (round_ff),
      .msg_word  (store_rd_word),
      .work_nxt  (work_rnd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign offset = count_ff[5:0];

   always_comb begin
      if (pad_first_ff) begin
         pad_byte = PAD_MARK;
      end else if (offset < LEN_OFFSET || !len_zone_ff) begin
         pad_byte = 8'h00;
      end else begin
         pad_byte = bits_ff[{offset[2:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      case (emit_idx_ff)
         IDX_A: emit_word = chain_ff.a;
         IDX_B: emit_word = chain_ff.b;
         IDX_C: emit_word = chain_ff.c;
         default: emit_word = chain_ff.d;
      endcase
   end

   always_comb begin
      store_rd_addr = md5_msg_index(round_ff + 6'd1);
      if (state_ff == ST_LOAD) begin
         store_rd_addr = md5_msg_index(6'd0);
      end
   end

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      work_in = work_ff;
      count_in = count_ff;
      bits_in = bits_ff;
      round_in = round_ff;
      finishing_in = finishing_ff;
      pad_first_in = pad_first_ff;
      len_zone_in = len_zone_ff;
      len_done_in = len_done_ff;
      emit_idx_in = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      store_wr.en = 1'b0;
      store_wr.addr = offset;
      store_wr.data = pad_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_BYTE) begin
                  store_wr.en = 1'b1;
                  store_wr.data = req_tdata;
                  count_in = count_ff + 64'd1;
                  if (offset == LAST_OFFSET) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  bits_in = {count_ff[60:0], 3'b000};
                  finishing_in = 1'b1;
                  pad_first_in = 1'b1;
                  len_zone_in = (offset < LEN_OFFSET);
                  len_done_in = 1'b0;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            store_wr.en = 1'b1;
            count_in = count_ff + 64'd1;
            pad_first_in = 1'b0;
            if (offset == LAST_OFFSET) begin
               len_done_in = len_zone_ff;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            work_in = chain_ff;
            round_in = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in = work_rnd;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            if (!finishing_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               emit_idx_in = IDX_A;
               state_in = ST_EMIT;
            end else begin
               len_zone_in = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = emit_word;
               rsp_user_in = emit_idx_ff;
               rsp_last_in = (emit_idx_ff == IDX_D);
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (emit_idx_ff == IDX_D) begin
                  chain_in.a = INIT_A;
                  chain_in.b = INIT_B;
                  chain_in.c = INIT_C;
                  chain_in.d = INIT_D;
                  count_in = 64'd0;
                  finishing_in = 1'b0;
                  len_done_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff.a <= INIT_A;
         chain_ff.b <= INIT_B;
         chain_ff.c <= INIT_C;
         chain_ff.d <= INIT_D;
         count_ff <= 64'd0;
         round_ff <= 6'd0;
         finishing_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         len_zone_ff <= 1'b0;
         len_done_ff <= 1'b0;
         emit_idx_ff <= IDX_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         round_ff <= round_in;
         finishing_ff <= finishing_in;
         pad_first_ff <= pad_first_in;
         len_zone_ff <= len_zone_in;
         len_done_ff <= len_done_in;
         emit_idx_ff <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff <= work_in;
      bits_ff <= bits_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a digest word is pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == IDX_D)
      else $error("last digest word is not word D");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_FINISH |=> !req_tready)
      else $error("finish word did not start padding");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && count_ff == 64'd0)
      else $error("engine not back to its initial state after the digest");

endmodule

// ===== tb/tb_md5_hash_engine.sv =====
// Self-checking testbench for md5_hash_engine: directed messages, then random messages
// with idle and stall phases, every digest word checked against an MD5 predictor or a known digest.
// Depends on md5_pkg and md5_hash_engine.

module tb_md5_hash_engine;
   import md5_pkg::*;

   typedef logic [3:0][31:0] digest_type;

   typedef struct packed {
      logic [0:0] op;
      logic [7:0] data;
      logic       typed;
      digest_type dig;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  idx;
      logic        last;
   } digest_word_type;

   localparam digest_type EMPTY_MSG_DIGEST =
      {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
   localparam digest_type ABC_MSG_DIGEST =
      {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // data_byte[7:0]
   logic [0:0]  req_tuser = OP_BYTE;  // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // digest_word[31:0]
   logic [1:0]  rsp_tuser;            // word_index[1:0]
   logic        rsp_tlast;

   logic [31:0]     round_sine [64];
   int              round_shift [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                           '{4, 11, 16, 23}, '{6, 10, 15, 21}};
   int              boundary_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
   logic [31:0]     chain_words [4];
   logic [7:0]      block_bytes [64];
   logic [63:0]     byte_total;
   digest_word_type digest_words_due [$];
   digest_word_type due_word;
   stim_row_type    directed_rows [$];
   int              error_count = 0;
   int              words_sent = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;

   md5_hash_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   task automatic md5_restart();
      chain_words[0] = 32'h67452301;
      chain_words[1] = 32'hefcdab89;
      chain_words[2] = 32'h98badcfe;
      chain_words[3] = 32'h10325476;
      byte_total = '0;
   endtask

   task automatic compress_model();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int k;
      for (int r = 0; r < 16; r++)
         m[r] = {block_bytes[4*r+3], block_bytes[4*r+2], block_bytes[4*r+1], block_bytes[4*r]};
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               k = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               k = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               k = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               k = (7 * r) % 16;
            end
         endcase
         t = f + a + round_sine[r] + m[k];
         a = d;
         d = c;
         c = b;
         b = b + rotl32(t, round_shift[r / 16][r % 4]);
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endtask

   task automatic push_model_byte(input logic [7:0] v);
      block_bytes[byte_total[5:0]] = v;
      byte_total++;
      if (byte_total[5:0] == 6'd0)
         compress_model();
   endtask

   // Folds one accepted word into the running hash; a finish returns the digest.
   task automatic md5_absorb(input logic [0:0] op, input logic [7:0] v,
                             output digest_type dig);
      logic [63:0] bit_len;
      dig = '0;
      if (op == OP_BYTE) begin
         push_model_byte(v);
      end else begin
         bit_len = byte_total << 3;
         push_model_byte(8'h80);
         while (byte_total[5:0] != 6'd56)
            push_model_byte(8'h00);
         for (int i = 0; i < 8; i++)
            push_model_byte(bit_len[8*i +: 8]);
         for (int i = 0; i < 4; i++)
            dig[i] = chain_words[i];
         md5_restart();
      end
   endtask

   task automatic send_word(input logic [0:0] op, input logic [7:0] v, input logic typed,
                            input digest_type typed_dig);
      digest_type dig;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      md5_absorb(op, v, dig);
      if (op == OP_FINISH) begin
         if (typed)
            dig = typed_dig;
         for (int i = 0; i < 4; i++)
            digest_words_due.push_back('{dig[i], 2'(i), (2'(i) == IDX_D)});
      end
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (digest_words_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_phase(input int p);
      case (p)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 45;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 45;
         end
         default: begin
            send_idle_pct = 17;
            recv_stall_pct = 17;
         end
      endcase
   endtask

   always @(posedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_words_due.size() == 0) begin
            $display("%0t: unexpected digest word, expected none, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            due_word = digest_words_due.pop_front();
            if (rsp_tdata !== due_word.word) begin
               $display("%0t: digest_word expected %h actual %h", $time, due_word.word,
                        rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== due_word.idx) begin
               $display("%0t: word_index expected %0d actual %0d", $time, due_word.idx,
                        rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== due_word.last) begin
               $display("%0t: last_word expected %b actual %b", $time, due_word.last,
                        rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(20 * 500000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      real          sine_val;
      int           len;
      int           msgs;
      int           pick;
      logic [7:0]   b;
      stim_row_type row;

      for (int i = 0; i < 64; i++) begin
         sine_val = $sin(i + 1);
         if (sine_val < 0.0)
            sine_val = -sine_val;
         round_sine[i] = 32'(longint'($floor(sine_val * 4294967296.0)));
      end
      md5_restart();

      // Empty message, data ignored on finish, a short known string, then field extremes.
      directed_rows.push_back('{OP_FINISH, 8'h00, 1'b1, EMPTY_MSG_DIGEST});
      directed_rows.push_back('{OP_FINISH, 8'hff, 1'b1, EMPTY_MSG_DIGEST});
      directed_rows.push_back('{OP_BYTE, 8'h61, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'h62, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'h63, 1'b0, '0});
      directed_rows.push_back('{OP_FINISH, 8'h5a, 1'b1, ABC_MSG_DIGEST});
      directed_rows.push_back('{OP_BYTE, 8'h00, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'hff, 1'b0, '0});
      directed_rows.push_back('{OP_FINISH, 8'h00, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'h55, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'haa, 1'b0, '0});
      directed_rows.push_back('{OP_FINISH, 8'ha5, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'h80, 1'b0, '0});
      directed_rows.push_back('{OP_BYTE, 8'h01, 1'b0, '0});
      directed_rows.push_back('{OP_FINISH, 8'hff, 1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_word(row.op, row.data, row.typed, row.dig);
      end

      // Random messages; a quarter of the lengths sit on the padding boundaries around 56, 64, 120 and 128 bytes.
      msgs = 0;
      while (words_sent < 370 || msgs < 8) begin
         if (msgs % 2 == 0) begin
            wait_drained();
            set_phase((msgs / 2) % 4);
         end
         pick = $urandom_range(0, 99);
         if (pick < 25)
            len = boundary_len[$urandom_range(0, 9)];
         else if (pick < 30)
            len = $urandom_range(129, 200);
         else
            len = $urandom_range(0, 20);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
            send_word(OP_BYTE, b, 1'b0, '0);
         end
         send_word(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
         msgs++;
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
